/* hdl/micrt_pkg.sv */
// ----------------------------------------------------------------------------
// Modular inverse / CRT package
// Shared widths and status codes.
// ----------------------------------------------------------------------------
package micrt_pkg;
	localparam int MODULUS_BITS_DEF = 31;
	localparam int RESULT_W = 62;
	localparam int GCD_W = 31;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_ZERO_MOD  = 2'd1,
		ST_NOT_COPRI = 2'd2
	} status_t;
endpackage

/* hdl/modular_inverse_crt_unit.sv */
// ----------------------------------------------------------------------------
// Modular inverse and two-residue CRT unit
// Extended Euclid over one shared serial divider, then Garner combination.
// A word takes up to about 52 divisions (up to about 46 Euclid steps).
// A zero modulus answers in the cycle after acceptance.
// Throughput: one word at a time; in_ready stays low until the result is taken.
// Reset: asynchronous, clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module modular_inverse_crt_unit #(
	parameter int MODULUS_BITS = micrt_pkg::MODULUS_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         action,
	input  logic signed [31:0]           value_a,
	input  logic signed [31:0]           value_b,
	input  logic [30:0]                  modulus_m,
	input  logic [30:0]                  modulus_n,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [micrt_pkg::RESULT_W-1:0] result,
	output logic [micrt_pkg::GCD_W-1:0]   gcd_value,
	output logic [1:0]                   status
);
	localparam int NW = 64;
	localparam int DW = 32;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_RA   = 10'b0000000010,
		S_RB   = 10'b0000000100,
		S_EU   = 10'b0000001000,
		S_XR   = 10'b0000010000,
		S_AN   = 10'b0000100000,
		S_DN   = 10'b0001000000,
		S_TN   = 10'b0010000000,
		S_FIN  = 10'b0100000000,
		S_OUT  = 10'b1000000000
	} state_t;

	state_t state_q;
	logic                 act_q;
	logic signed [32:0]   va_q, vb_q;
	logic [30:0]          m_q, n_q;
	logic [31:0]          ar_q, br_q, xr_q, anr_q;
	logic [30:0]          p_q, q_q;
	logic signed [63:0]   px_q, qx_q;
	logic                 wait_q;

	logic                 dv_start, dv_done;
	logic [NW-1:0]        dv_num, dv_quo;
	logic [DW-1:0]        dv_den, dv_rem;

	micrt_divu #(.NW(NW), .DW(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .num(dv_num), .den(dv_den),
		.done(dv_done), .quo(dv_quo), .rem(dv_rem)
	);

	logic [30:0] mmask, nmask;
	assign mmask = 31'(modulus_m & ((64'd1 << MODULUS_BITS) - 64'd1));
	assign nmask = 31'(modulus_n & ((64'd1 << MODULUS_BITS) - 64'd1));

	// signed reduction helper: reduce |v| then fix sign
	function automatic logic [31:0] fixneg(input logic neg, input logic [31:0] r,
		input logic [30:0] m);
		logic [31:0] o;
		o = (neg && r != 32'd0) ? ({1'b0, m} - r) : r;
		return o;
	endfunction

	logic [63:0] abs_a, abs_b, abs_px;
	assign abs_a  = va_q[32] ? 64'(-va_q) : 64'(va_q);
	assign abs_b  = vb_q[32] ? 64'(-vb_q) : 64'(vb_q);
	assign abs_px = qx_q[63] ? 64'(-qx_q) : 64'(qx_q);

	logic signed [31:0] kq;
	logic signed [32:0] qx_n;
	logic signed [64:0] kprod;
	logic signed [63:0] nx;
	logic [63:0] prod_q;
	assign kq    = $signed({1'b0, dv_quo[30:0]});
	assign qx_n  = qx_q[32:0];
	assign kprod = kq * qx_n;
	assign nx    = px_q - $signed(kprod[63:0]);

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			dv_start  <= 1'b0;
			wait_q    <= 1'b0;
		end else begin
			dv_start <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						act_q <= action;
						va_q  <= 33'(value_a);
						vb_q  <= 33'(value_b);
						m_q   <= mmask;
						n_q   <= nmask;
						if (mmask == '0 || (action && nmask == '0)) begin
							result    <= '0;
							gcd_value <= '0;
							status    <= micrt_pkg::ST_ZERO_MOD;
							out_valid <= 1'b1;
							state_q   <= S_OUT;
						end else begin
							state_q <= S_RA;
							wait_q  <= 1'b0;
						end
					end
				end
				S_RA: begin
					if (!wait_q) begin
						dv_num <= abs_a; dv_den <= {1'b0, m_q};
						dv_start <= 1'b1; wait_q <= 1'b1;
					end else if (dv_done) begin
						wait_q <= 1'b0;
						ar_q <= fixneg(va_q[32], dv_rem, m_q);
						if (act_q) state_q <= S_RB;
						else begin
							p_q <= 31'(fixneg(va_q[32], dv_rem, m_q));
							q_q <= m_q; px_q <= 64'sd1; qx_q <= '0;
							state_q <= S_EU;
						end
					end
				end
				S_RB: begin
					if (!wait_q) begin
						dv_num <= abs_b; dv_den <= {1'b0, n_q};
						dv_start <= 1'b1; wait_q <= 1'b1;
					end else if (dv_done) begin
						wait_q <= 1'b0;
						br_q <= fixneg(vb_q[32], dv_rem, n_q);
						p_q <= m_q; q_q <= n_q; px_q <= 64'sd1; qx_q <= '0;
						state_q <= S_EU;
					end
				end
				S_EU: begin
					if (!wait_q) begin
						dv_num <= 64'(p_q); dv_den <= {1'b0, q_q};
						dv_start <= 1'b1; wait_q <= 1'b1;
					end else if (dv_done) begin
						wait_q <= 1'b0;
						if (dv_rem == '0) begin
							gcd_value <= q_q;
							if (q_q != 31'd1) begin
								result <= '0; status <= micrt_pkg::ST_NOT_COPRI;
								out_valid <= 1'b1; state_q <= S_OUT;
							end else state_q <= S_XR;
						end else begin
							p_q <= q_q; px_q <= qx_q;
							q_q <= dv_rem[30:0]; qx_q <= nx;
						end
					end
				end
				S_XR: begin
					if (!wait_q) begin
						dv_num <= abs_px; dv_den <= {1'b0, act_q ? n_q : m_q};
						dv_start <= 1'b1; wait_q <= 1'b1;
					end else if (dv_done) begin
						wait_q <= 1'b0;
						if (!act_q) begin
							result <= 62'(fixneg(qx_q[63], dv_rem, m_q));
							status <= micrt_pkg::ST_OK;
							out_valid <= 1'b1; state_q <= S_OUT;
						end else begin
							xr_q <= fixneg(qx_q[63], dv_rem, n_q);
							state_q <= S_AN;
						end
					end
				end
				S_AN: begin
					if (!wait_q) begin
						dv_num <= 64'(ar_q); dv_den <= {1'b0, n_q};
						dv_start <= 1'b1; wait_q <= 1'b1;
					end else if (dv_done) begin
						wait_q <= 1'b0;
						anr_q <= dv_rem;
						state_q <= S_DN;
					end
				end
				S_DN: begin
					if (!wait_q) begin
						dv_num <= 64'(br_q) + 64'(n_q) - 64'(anr_q);
						dv_den <= {1'b0, n_q};
						dv_start <= 1'b1; wait_q <= 1'b1;
					end else if (dv_done) begin
						wait_q <= 1'b0;
						prod_q <= dv_rem * xr_q;
						state_q <= S_TN;
					end
				end
				S_TN: begin
					if (!wait_q) begin
						dv_num <= prod_q; dv_den <= {1'b0, n_q};
						dv_start <= 1'b1; wait_q <= 1'b1;
					end else if (dv_done) begin
						wait_q <= 1'b0;
						prod_q <= m_q * dv_rem;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					result <= 62'(prod_q + 64'(ar_q));
					status <= micrt_pkg::ST_OK;
					out_valid <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* hdl/micrt_divu.sv */
// ----------------------------------------------------------------------------
// Shared restoring divider
// Unsigned division, one quotient bit per cycle; wide dividend, narrow divisor.
// ----------------------------------------------------------------------------
module micrt_divu #(
	parameter int NW = 64,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem
);
	localparam int CW = $clog2(NW + 1);
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [NW-1:0] q_q;
	logic [DW:0]   r_q;
	logic [DW:0]   trial;
	logic [DW:0]   shifted;

	assign shifted = {r_q[DW-1:0], q_q[NW-1]};
	assign trial   = shifted - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
		end else if (busy_q) begin
			if (!trial[DW]) begin
				r_q <= trial;
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				r_q <= shifted;
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	assign quo = q_q;
	assign rem = r_q[DW-1:0];
endmodule

/* verif/tb_modular_inverse_crt_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular inverse / CRT unit testbench
// Drives inverse and CRT words with random idling on both sides, predicts each
// result with an extended Euclid model and compares every output word.
// ----------------------------------------------------------------------------
module tb_modular_inverse_crt_unit;
	typedef struct {
		logic        action;
		logic [31:0] value_a;
		logic [31:0] value_b;
		logic [30:0] modulus_m;
		logic [30:0] modulus_n;
	} request_t;

	typedef struct {
		logic [61:0]          result;
		logic [30:0]          gcd_value;
		micrt_pkg::status_t   status;
	} answer_t;

	localparam logic OP_INVERSE = 1'b0;
	localparam logic OP_CRT     = 1'b1;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic action;
	logic signed [31:0] value_a;
	logic signed [31:0] value_b;
	logic [30:0] modulus_m;
	logic [30:0] modulus_n;
	logic out_valid;
	logic out_ready;
	logic [61:0] result;
	logic [30:0] gcd_value;
	logic [1:0] status;

	request_t pending_q[$];
	answer_t  answer_q[$];
	int       mismatches;
	int       send_gap;
	int       recv_gap;
	int       hold_off;

	modular_inverse_crt_unit u_top (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.action(action), .value_a(value_a), .value_b(value_b),
		.modulus_m(modulus_m), .modulus_n(modulus_n), .out_valid(out_valid),
		.out_ready(out_ready), .result(result), .gcd_value(gcd_value), .status(status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint residue(longint v, longint m);
		longint r;
		r = v % m;
		if (r < 0) r += m;
		return r;
	endfunction

	function automatic longint bezout(longint p, longint q, output longint coef);
		longint px, qx, k, nr, nx;
		px = 1;
		qx = 0;
		forever begin
			k = p / q;
			nr = p - k * q;
			nx = px - k * qx;
			if (nr == 0) begin
				coef = qx;
				return q;
			end
			p = q; px = qx; q = nr; qx = nx;
		end
	endfunction

	function automatic answer_t solve_request(request_t r);
		answer_t a;
		longint m, n, ar, br, g, coef, xr, d, t;
		m = longint'(r.modulus_m);
		n = longint'(r.modulus_n);
		a.result = '0;
		a.gcd_value = '0;
		a.status = micrt_pkg::ST_OK;
		if (r.action == OP_INVERSE) begin
			if (m == 0) begin
				a.status = micrt_pkg::ST_ZERO_MOD;
			end else begin
				ar = residue(longint'($signed(r.value_a)), m);
				g = bezout(ar, m, coef);
				a.gcd_value = g[30:0];
				if (g != 1) a.status = micrt_pkg::ST_NOT_COPRI;
				else a.result = 62'(residue(coef, m));
			end
		end else begin
			if (m == 0 || n == 0) begin
				a.status = micrt_pkg::ST_ZERO_MOD;
			end else begin
				ar = residue(longint'($signed(r.value_a)), m);
				br = residue(longint'($signed(r.value_b)), n);
				g = bezout(m, n, coef);
				a.gcd_value = g[30:0];
				if (g != 1) begin
					a.status = micrt_pkg::ST_NOT_COPRI;
				end else begin
					xr = residue(coef, n);
					d = (br + n - (ar % n)) % n;
					t = longint'((64'(d) * 64'(xr)) % 64'(n));
					a.result = 62'(ar + m * t);
				end
			end
		end
		return a;
	endfunction

	function automatic logic [30:0] pick_modulus();
		case ($urandom_range(0, 5))
			0: return 31'($urandom_range(1, 16));
			1: return 31'($urandom_range(1, 1000));
			2: return 31'h7fffffff - 31'($urandom_range(0, 100));
			3: return 31'($urandom_range(0, 3)) * 31'($urandom_range(2, 13));
			default: return 31'($urandom);
		endcase
	endfunction

	task automatic push_request(logic op, logic [31:0] va, logic [31:0] vb,
			logic [30:0] m, logic [30:0] n);
		request_t r;
		r.action = op;
		r.value_a = va;
		r.value_b = vb;
		r.modulus_m = m;
		r.modulus_n = n;
		pending_q = {pending_q, r};
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else if (in_valid && !in_ready) begin
			in_valid <= 1'b1;
		end else if (send_gap > 0) begin
			in_valid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (pending_q.size() > 0) begin
			request_t r;
			r = pending_q.pop_front();
			answer_q = {answer_q, solve_request(r)};
			in_valid <= 1'b1;
			action <= r.action;
			value_a <= r.value_a;
			value_b <= r.value_b;
			modulus_m <= r.modulus_m;
			modulus_n <= r.modulus_n;
			send_gap <= $urandom_range(0, 5);
		end else begin
			in_valid <= 1'b0;
		end
	end

	// receiver stall control
	always @(posedge clk or negedge arst_n) begin
		int draw;
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap <= 0;
		end else if (hold_off > 0) begin
			out_ready <= 1'b0;
			hold_off <= hold_off - 1;
		end else if (out_valid && out_ready) begin
			draw = $urandom_range(0, 5);
			recv_gap <= draw;
			out_ready <= (draw == 0);
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			out_ready <= (recv_gap == 1);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			answer_t e;
			if (answer_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word: result=%h", result);
			end else begin
				e = answer_q.pop_front();
				if (result !== e.result || gcd_value !== e.gcd_value ||
						status !== 2'(e.status)) begin
					mismatches++;
					if (mismatches <= 10)
						$display("exp %h/%h/%0d got %h/%h/%0d", e.result, e.gcd_value,
							e.status, result, gcd_value, status);
				end
			end
		end
	end

	initial begin
		action = 1'b0;
		value_a = '0;
		value_b = '0;
		modulus_m = '0;
		modulus_n = '0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		hold_off = 0;
		mismatches = 0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		push_request(OP_INVERSE, 32'd3, 32'd0, 31'd7, 31'd0);
		push_request(OP_INVERSE, 32'h80000000, 32'hffffffff, 31'h7fffffff, 31'd5);
		push_request(OP_INVERSE, 32'h7fffffff, 32'd0, 31'h7ffffffe, 31'd0);
		push_request(OP_INVERSE, 32'hffffffff, 32'd0, 31'd1000, 31'd0);
		push_request(OP_INVERSE, 32'd5, 32'd0, 31'd0, 31'd9);
		push_request(OP_INVERSE, 32'd6, 32'd0, 31'd9, 31'd0);
		push_request(OP_INVERSE, 32'd0, 32'd0, 31'd1, 31'd0);
		push_request(OP_INVERSE, 32'd0, 32'd0, 31'd12, 31'd0);
		push_request(OP_INVERSE, 32'd1134903170, 32'd0, 31'd1836311903, 31'd0);
		push_request(OP_CRT, 32'd2, 32'd3, 31'd3, 31'd5);
		push_request(OP_CRT, 32'h80000000, 32'h7fffffff, 31'h7fffffff, 31'h7ffffffe);
		push_request(OP_CRT, 32'hffffffff, 32'h80000000, 31'h7ffffffe, 31'h7ffffffd);
		push_request(OP_CRT, 32'd1, 32'd1, 31'd0, 31'd5);
		push_request(OP_CRT, 32'd1, 32'd1, 31'd5, 31'd0);
		push_request(OP_CRT, 32'd4, 32'd9, 31'd6, 31'd10);
		push_request(OP_CRT, 32'd7, 32'd0, 31'd1, 31'd1);
		push_request(OP_CRT, 32'd0, 32'd7, 31'd1, 31'd13);
		push_request(OP_CRT, 32'd5, 32'd3, 31'd1836311903, 31'd1134903170);
		push_request(OP_CRT, 32'd5, 32'd3, 31'd13, 31'd13);

		// long receiver stall while the sender keeps offering
		for (int i = 0; i < 6; i++)
			push_request(OP_INVERSE, $urandom, $urandom, pick_modulus(), pick_modulus());
		hold_off = 9000;
		wait (pending_q.size() == 0);

		// sender pauses until the block drains
		wait (answer_q.size() == 0);

		for (int i = 0; i < 265; i++) begin
			if (pending_q.size() > 4) wait (pending_q.size() <= 4);
			push_request(logic'($urandom_range(0, 1)), $urandom, $urandom,
				pick_modulus(), pick_modulus());
		end
		wait (pending_q.size() == 0 && !in_valid);
		wait (answer_q.size() == 0);
		repeat (4000) @(posedge clk);
		if (mismatches == 0 && answer_q.size() == 0)
			$display("modular_inverse_crt_unit: match");
		else
			$display("modular_inverse_crt_unit: mismatch");
		$finish;
	end

	initial begin
		#60ms;
		$display("modular_inverse_crt_unit: mismatch");
		$finish;
	end
endmodule

/* sim.f */
hdl/micrt_pkg.sv
hdl/micrt_divu.sv
hdl/modular_inverse_crt_unit.sv
verif/tb_modular_inverse_crt_unit.sv
